// ----- sv/bcmc_pkg.sv -----
// Package for the battery charge mode controller: mode, source and off-reason
// codes, configuration register indexes, reset values and field widths.
// No dependencies.
`default_nettype none

package bcmc_pkg;

  // Field widths
  localparam int unsigned TEMP_W = 12;
  localparam int unsigned MV_W   = 14;
  localparam int unsigned CUR_W  = 23;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned SRC_W  = 2;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned TMO_W  = 16;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 16;

  // Charge modes
  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_SLOW = 2'd1,
    MODE_FAST = 2'd2,
    MODE_BDIS = 2'd3
  } mode_t;

  // Applied mode is one bit wider so that reset can mean "nothing applied yet".
  localparam logic [2:0] APPLIED_NONE = 3'd7;

  // Charge source codes
  localparam logic [SRC_W-1:0] SRC_NONE = 2'd0;
  localparam logic [SRC_W-1:0] SRC_USB  = 2'd1;
  localparam logic [SRC_W-1:0] SRC_AC   = 2'd2;

  // Reasons for charging being off
  typedef enum logic [2:0] {
    REASON_NONE     = 3'd0,
    REASON_OVERTEMP = 3'd1,
    REASON_COOLDOWN = 3'd2,
    REASON_FULL     = 3'd3,
    REASON_TIMEOUT  = 3'd4
  } reason_t;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_TEMP_CRITICAL    = 3'd0,
    CFG_TEMP_HOT         = 3'd1,
    CFG_TEMP_WARM        = 3'd2,
    CFG_HOT_MAX_MV       = 3'd3,
    CFG_HOT_MIN_MV       = 3'd4,
    CFG_DISABLE_MIN_MV   = 3'd5,
    CFG_FULL_PERCENT     = 3'd6,
    CFG_CHARGE_TIMEOUT_S = 3'd7
  } cfg_idx_t;

  // Configuration reset values
  localparam logic signed [TEMP_W-1:0] RST_TEMP_CRITICAL = 12'sd600;
  localparam logic signed [TEMP_W-1:0] RST_TEMP_HOT      = 12'sd500;
  localparam logic signed [TEMP_W-1:0] RST_TEMP_WARM     = 12'sd450;
  localparam logic [MV_W-1:0]          RST_HOT_MAX_MV    = 14'd4100;
  localparam logic [MV_W-1:0]          RST_HOT_MIN_MV    = 14'd3800;
  localparam logic [MV_W-1:0]          RST_DISABLE_MIN_MV = 14'd4100;
  localparam logic [PCT_W-1:0]         RST_FULL_PERCENT  = 7'd99;
  localparam logic [TMO_W-1:0]         RST_CHARGE_TIMEOUT = 16'd3600;

  // Current above which the battery counts as charging
  localparam logic signed [CUR_W-1:0] CHARGE_SEEN_UA = 23'sd1024;

endpackage

`default_nettype wire

// ----- sv/bcmc_if.sv -----
// Valid/ready channel interfaces for the charge mode controller: one for poll
// samples, one for results. Field widths come from bcmc_pkg.
`default_nettype none

interface bcmc_in_if
  import bcmc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic [MV_W-1:0]          voltage_mv;
  logic signed [CUR_W-1:0]  bat_current;
  logic [PCT_W-1:0]         charge_percent;
  logic [SRC_W-1:0]         power_source;
  logic                     over_charge;
  logic [TIME_W-1:0]        now_seconds;

  modport source (
    output valid, temperature, voltage_mv, bat_current, charge_percent,
           power_source, over_charge, now_seconds,
    input  ready
  );
  modport sink (
    input  valid, temperature, voltage_mv, bat_current, charge_percent,
           power_source, over_charge, now_seconds,
    output ready
  );
endinterface

interface bcmc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       charger_on;
  logic       fast_current;
  logic       poke;
  logic       mode_changed;
  logic       full_reached;
  logic       cooling_down;
  logic [2:0] off_reason;

  modport source (
    output valid, mode, charger_on, fast_current, poke, mode_changed,
           full_reached, cooling_down, off_reason,
    input  ready
  );
  modport sink (
    input  valid, mode, charger_on, fast_current, poke, mode_changed,
           full_reached, cooling_down, off_reason,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/battery_charge_mode_controller_top.sv -----
// Top level of the battery charge mode controller.
// Depends on bcmc_pkg and the channel interfaces in bcmc_if.sv.
//
// Usage:
//   in_chan carries one poll sample per item (temperature, voltage, current,
//   state of charge, source, over-charge pin, time). out_chan returns exactly
//   one result item per sample: the chosen mode, the charger line levels,
//   poke and change flags, full and cooldown status, and the off reason.
//   The cfg_ port writes the eight threshold registers by index; write them
//   only while no sample is in flight.
//
//   A sample is captured in an input register; the mode decision is one
//   level of compare logic between that register and the result register,
//   so a result is loaded into the result register as its sample leaves the
//   input register. One sample is accepted every cycle while out_chan does
//   not stall; the state written by one sample is read by the next.
//
//   Reset clears the cooldown flag, marks no mode applied, clears the last
//   charging time, drives the enable line off and the fast line high, and
//   restores the threshold defaults. When out_chan stalls, the result is
//   held, one more sample waits in the input register, then in_chan.ready
//   drops until the result is taken.
`default_nettype none

module battery_charge_mode_controller_top
  import bcmc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  bcmc_in_if.sink                in_chan,
  bcmc_out_if.source             out_chan,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  // Configuration registers
  logic signed [TEMP_W-1:0] temp_critical_r, temp_hot_r, temp_warm_r;
  logic [MV_W-1:0]          hot_max_mv_r, hot_min_mv_r, disable_min_mv_r;
  logic [PCT_W-1:0]         full_percent_r;
  logic [TMO_W-1:0]         charge_timeout_r;

  // Input register
  logic                     in_valid_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [MV_W-1:0]          volt_r;
  logic signed [CUR_W-1:0]  cur_r;
  logic [PCT_W-1:0]         pct_r;
  logic [SRC_W-1:0]         src_raw_r;
  logic                     ovp_r;
  logic [TIME_W-1:0]        now_r;

  // Controller state
  logic              cooldown_r, cooldown_nxt;
  logic [2:0]        applied_r, applied_nxt;
  logic [TIME_W-1:0] last_seen_r, last_seen_nxt;
  logic              enable_r, enable_nxt;
  logic              fast_r, fast_nxt;

  // Result register
  logic    out_valid_r;
  mode_t   mode_r, mode_nxt;
  logic    poke_r, poke_nxt;
  logic    changed_r, changed_nxt;
  logic    full_r, full_nxt;
  reason_t reason_r, reason_nxt;

  // Handshake
  logic in_accept, fire;
  assign fire      = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_accept = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !in_valid_r || fire;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_critical_r  <= RST_TEMP_CRITICAL;
      temp_hot_r       <= RST_TEMP_HOT;
      temp_warm_r      <= RST_TEMP_WARM;
      hot_max_mv_r     <= RST_HOT_MAX_MV;
      hot_min_mv_r     <= RST_HOT_MIN_MV;
      disable_min_mv_r <= RST_DISABLE_MIN_MV;
      full_percent_r   <= RST_FULL_PERCENT;
      charge_timeout_r <= RST_CHARGE_TIMEOUT;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEMP_CRITICAL:    temp_critical_r  <= cfg_wdata[TEMP_W-1:0];
        CFG_TEMP_HOT:         temp_hot_r       <= cfg_wdata[TEMP_W-1:0];
        CFG_TEMP_WARM:        temp_warm_r      <= cfg_wdata[TEMP_W-1:0];
        CFG_HOT_MAX_MV:       hot_max_mv_r     <= cfg_wdata[MV_W-1:0];
        CFG_HOT_MIN_MV:       hot_min_mv_r     <= cfg_wdata[MV_W-1:0];
        CFG_DISABLE_MIN_MV:   disable_min_mv_r <= cfg_wdata[MV_W-1:0];
        CFG_FULL_PERCENT:     full_percent_r   <= cfg_wdata[PCT_W-1:0];
        CFG_CHARGE_TIMEOUT_S: charge_timeout_r <= cfg_wdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: payload loads on accept, valid tracks occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      temp_r    <= in_chan.temperature;
      volt_r    <= in_chan.voltage_mv;
      cur_r     <= in_chan.bat_current;
      pct_r     <= in_chan.charge_percent;
      src_raw_r <= in_chan.power_source;
      ovp_r     <= in_chan.over_charge;
      now_r     <= in_chan.now_seconds;
    end
  end

  // Mode decision for the sample in the input register.
  logic [SRC_W-1:0]  src;
  logic              is_full, is_hot, is_crit, is_warm, cd_set;
  logic              charging, timeout_due, timed_out;
  logic [TIME_W-1:0] elapsed;
  mode_t             m;

  always_comb begin
    // An unused source code counts as no source.
    src = (src_raw_r == SRC_NONE || src_raw_r == SRC_USB || src_raw_r == SRC_AC)
          ? src_raw_r : SRC_NONE;
    m   = mode_t'(src);

    cooldown_nxt  = cooldown_r;
    last_seen_nxt = last_seen_r;
    enable_nxt    = enable_r;
    fast_nxt      = fast_r;
    applied_nxt   = applied_r;
    poke_nxt      = 1'b0;
    timed_out     = 1'b0;

    is_full = (pct_r >= full_percent_r);
    is_hot  = (temp_r >= temp_hot_r) || ovp_r;
    is_crit = (temp_r >= temp_critical_r);
    is_warm = (temp_r >= temp_warm_r);
    cd_set  = is_hot && (volt_r >= hot_max_mv_r);

    if (is_full) m = MODE_BDIS;
    if (is_hot && is_crit) m = MODE_BDIS;
    if (is_warm && m == MODE_FAST) m = MODE_SLOW;

    // Cooldown: armed when hot at max voltage, released on cooling or a drop.
    if (cooldown_r || cd_set) begin
      if (!is_warm || volt_r <= hot_min_mv_r) begin
        cooldown_nxt = 1'b0;
      end else begin
        cooldown_nxt = 1'b1;
        m = MODE_BDIS;
      end
    end

    // Charging timeout, with a poke for a charger in battery-disable mode.
    elapsed     = now_r - last_seen_r;
    charging    = (cur_r > CHARGE_SEEN_UA);
    timeout_due = (applied_r != {1'b0, MODE_OFF}) &&
                  (elapsed > {{(TIME_W-TMO_W){1'b0}}, charge_timeout_r});
    if (charging) begin
      last_seen_nxt = now_r;
    end else if (timeout_due) begin
      if (applied_r == {1'b0, MODE_BDIS}) begin
        last_seen_nxt = now_r;
        poke_nxt      = 1'b1;
        enable_nxt    = 1'b1;
        fast_nxt      = (src == SRC_AC);
      end else begin
        timed_out = 1'b1;
        m = MODE_OFF;
      end
    end

    if (src == SRC_NONE) m = MODE_OFF;
    if (m == MODE_BDIS && volt_r < disable_min_mv_r) m = MODE_OFF;

    // Drive the charger lines on a change of applied mode (a poke also drives them).
    changed_nxt = (applied_r != {1'b0, m});
    if (changed_nxt) begin
      applied_nxt = {1'b0, m};
      if (m == MODE_OFF) begin
        enable_nxt = 1'b0;
        fast_nxt   = 1'b0;
      end else begin
        last_seen_nxt = now_r;
        enable_nxt    = 1'b1;
        fast_nxt      = (m == MODE_BDIS) ? (src == SRC_AC) : (m == MODE_FAST);
      end
    end

    // Off reason, by priority.
    reason_nxt = REASON_NONE;
    if (m == MODE_OFF || m == MODE_BDIS) begin
      if (is_crit)                      reason_nxt = REASON_OVERTEMP;
      else if (cooldown_nxt)            reason_nxt = REASON_COOLDOWN;
      else if (is_full)                 reason_nxt = REASON_FULL;
      else if (m == MODE_OFF && timed_out) reason_nxt = REASON_TIMEOUT;
    end

    mode_nxt = m;
    full_nxt = is_full;
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cooldown_r  <= 1'b0;
      applied_r   <= APPLIED_NONE;
      last_seen_r <= '0;
      enable_r    <= 1'b0;
      fast_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        cooldown_r  <= cooldown_nxt;
        applied_r   <= applied_nxt;
        last_seen_r <= last_seen_nxt;
        enable_r    <= enable_nxt;
        fast_r      <= fast_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      mode_r    <= mode_nxt;
      poke_r    <= poke_nxt;
      changed_r <= changed_nxt;
      full_r    <= full_nxt;
      reason_r  <= reason_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.mode         = mode_r;
  assign out_chan.charger_on   = enable_r;
  assign out_chan.fast_current = fast_r;
  assign out_chan.poke         = poke_r;
  assign out_chan.mode_changed = changed_r;
  assign out_chan.full_reached = full_r;
  assign out_chan.cooling_down = cooldown_r;
  assign out_chan.off_reason   = reason_r;

  // A change to off always drops both charger lines.
  a_off_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && changed_r && mode_r == MODE_OFF |-> !enable_r && !fast_r)
    else $error("charger lines not dropped on change to off");

  // An off reason is reported only for off or battery-disable.
  a_reason_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && reason_r != REASON_NONE |-> mode_r == MODE_OFF || mode_r == MODE_BDIS)
    else $error("off reason given for a charging mode");

  // A result always records the mode it applied.
  a_applied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> applied_r == {1'b0, mode_r})
    else $error("applied mode differs from reported mode");

  // The first sample after reset always reports a mode change.
  a_first_change: assert property (@(posedge clk) disable iff (!rst_n)
    fire && applied_r == APPLIED_NONE |=> changed_r)
    else $error("first sample did not report a mode change");

endmodule

`default_nettype wire
